/* rtl/core/abr_pkg.sv */
// ----------------------------------------------------------------------------
// Bitrate selector package
// Shared types, codes and constants of the adaptive bitrate selector.
// ----------------------------------------------------------------------------
package abr_pkg;

  // Fixed field widths.
  localparam int unsigned BYTES_W    = 24;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned REQ_W      = 23;
  localparam int unsigned BPS_W      = 32;
  localparam int unsigned BUF_W      = 16;
  localparam int unsigned SW_W       = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned SECS_W     = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned RATE_W     = 23;

  // Throughput dividend is bytes times 8000, which needs 37 bits.
  localparam int unsigned DIVIDEND_W = 37;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam int unsigned STEP_BPS    = 700000;
  localparam int unsigned BBA_STEP_MS = 5000;
  localparam logic [12:0] BITS_MS_SCALE = 13'd8000;
  localparam logic [13:0] MS_PER_S      = 14'd1000;
  localparam logic [BUF_W-1:0] TICK_MS  = 16'd100;

  // Multiplying a 32-bit value by this and dropping 34 bits divides it by five.
  localparam logic [BPS_W-1:0] RECIP5 = 32'hCCCC_CCCD;

  // Input commands.
  localparam logic CMD_CHUNK = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Selection modes.
  localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SMOOTH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BUFFER = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK = 1'd1;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_RAW;
  localparam logic [SECS_W-1:0] SECS_RESET = 4'd2;

  typedef struct packed {
    logic               command;
    logic [BYTES_W-1:0] chunk_bytes;
    logic [MS_W-1:0]    download_ms;
  } item_t;

  typedef struct packed {
    logic               request_valid;
    logic [LEVEL_W-1:0] level_index;
    logic [REQ_W-1:0]   request_bytes;
    logic               delay_request;
    logic [BPS_W-1:0]   measured_bps;
    logic [BPS_W-1:0]   smoothed_bps;
    logic [BUF_W-1:0]   buffer_level_ms;
    logic [SW_W-1:0]    switch_total;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_MUL,
    ST_DIV_T,
    ST_WAIT_T,
    ST_BUF,
    ST_DIV_S,
    ST_WAIT_S,
    ST_SELECT,
    ST_SIZE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic tick;
    logic mul;
    logic div_start;
    logic avg_start;
    logic take_bps;
    logic buf_add;
    logic take_avg;
    logic select;
    logic size;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              is_tick;
    logic [MODE_W-1:0] mode;
    logic              div_done;
    logic              avg_done;
    logic              out_free;
  } status_t;

  // Ladder rate of a level: 700000 * (level + 1) bit/s.
  function automatic logic [RATE_W-1:0] level_rate(input logic [LEVEL_W-1:0] lvl);
    logic [31:0] r;
    r = STEP_BPS * (32'(lvl) + 32'd1);
    return r[RATE_W-1:0];
  endfunction

endpackage

/* rtl/core/abr_div.sv */
// ----------------------------------------------------------------------------
// Bitrate selector divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module abr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [abr_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [abr_pkg::MS_W-1:0]          divisor,
  output logic [abr_pkg::DIVIDEND_W-1:0]    quotient,
  output logic                              busy,
  output logic                              done
);
  import abr_pkg::*;

  logic [MS_W:0]           rem;
  logic [DIVIDEND_W-1:0]   quo;
  logic [MS_W-1:0]         dvs;
  logic [DIV_CNT_W-1:0]    count;
  logic [MS_W:0]           rem_shift;
  logic                    fits;

  assign rem_shift = {rem[MS_W-1:0], quo[DIVIDEND_W-1]};
  assign fits      = rem_shift >= {1'b0, dvs};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? (rem_shift - {1'b0, dvs}) : rem_shift;
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

/* rtl/core/abr_datapath.sv */
// ----------------------------------------------------------------------------
// Bitrate selector datapath
// Holds the playback state, configuration and result register, and performs
// the arithmetic steps the controller commands.
// ----------------------------------------------------------------------------
module abr_datapath #(
  parameter int unsigned BUFFER_FULL_MS = 30000,
  parameter int unsigned LADDER_LEVELS  = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  abr_pkg::item_t                 item,
  input  abr_pkg::cmd_t                  cmd,
  output abr_pkg::status_t               status,
  output abr_pkg::result_t               result,
  output logic                           result_valid,
  input  logic                           result_stall,
  input  logic                           cfg_valid,
  input  logic [abr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import abr_pkg::*;

  // Configuration.
  logic [MODE_W-1:0] mode;
  logic [SECS_W-1:0] chunk_seconds;

  // Latched word and working values.
  item_t                 cur;
  logic [DIVIDEND_W-1:0] product;
  logic                  req_valid;
  logic [REQ_W-1:0]      req_bytes;
  logic                  delay;

  // Playback state.
  logic [BUF_W-1:0]   buffer_ms;
  logic [BPS_W-1:0]   avg_bps;
  logic [BPS_W-1:0]   last_bps;
  logic [LEVEL_W-1:0] next_level;
  logic               next_level_set;
  logic [LEVEL_W-1:0] prev_level;
  logic               prev_level_set;
  logic [SW_W-1:0]    switches;
  logic               draining;

  // Divider.
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [MS_W-1:0]       div_divisor;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic                  div_busy;
  logic                  div_done;

  // Moving average divide by five.
  logic [3:0]       avg_step;
  logic [BPS_W-1:0] recip_arg;
  logic [63:0]      recip_prod;
  logic [29:0]      recip_q;
  logic [29:0]      avg_qa;
  logic [29:0]      avg_ql;
  logic [2:0]       avg_ra;
  logic [2:0]       avg_rl;
  logic [4:0]       rem_sum;
  logic [2:0]       rem_carry;
  logic [BPS_W-1:0] avg_quo_sum;
  logic [BPS_W-1:0] avg_quo;

  // Combinational helpers.
  logic [BPS_W-1:0]   sel_bw;
  logic               q_found;
  logic [LEVEL_W-1:0] q_level;
  logic [LEVEL_W-1:0] b_level;
  logic [BUF_W:0]     buf_sum;
  logic [26:0]        size_prod;
  logic               out_free;

  assign div_dividend = product;
  assign div_divisor  = cur.download_ms;

  abr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  // (4*avg + last)/5 is split as 4*(avg/5) + last/5 plus the carry out of
  // the two remainders, so one 32-bit reciprocal multiply serves both.
  assign recip_arg  = avg_step[0] ? avg_bps : last_bps;
  assign recip_prod = 64'(recip_arg) * 64'(RECIP5);
  assign recip_q    = recip_prod[63:34];

  // Remainders are below five, so the low three bits are exact.
  assign avg_ra  = avg_bps[2:0] - (avg_qa[2:0] + {avg_qa[0], 2'b00});
  assign avg_rl  = last_bps[2:0] - (avg_ql[2:0] + {avg_ql[0], 2'b00});
  assign rem_sum = {avg_ra, 2'b00} + 5'(avg_rl);

  always_comb begin
    rem_carry = 3'd0;
    if (rem_sum >= 5'd20) begin
      rem_carry = 3'd4;
    end else if (rem_sum >= 5'd15) begin
      rem_carry = 3'd3;
    end else if (rem_sum >= 5'd10) begin
      rem_carry = 3'd2;
    end else if (rem_sum >= 5'd5) begin
      rem_carry = 3'd1;
    end
  end

  assign avg_quo_sum = {avg_qa, 2'b00} + BPS_W'(avg_ql) + BPS_W'(rem_carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_step <= '0;
    end else begin
      avg_step <= {avg_step[2:0], cmd.avg_start};
    end
  end

  always_ff @(posedge clk) begin
    if (avg_step[0]) begin
      avg_qa <= recip_q;
    end
    if (avg_step[1]) begin
      avg_ql <= recip_q;
    end
    if (avg_step[2]) begin
      avg_quo <= avg_quo_sum;
    end
  end

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    status.is_tick  = (cur.command == CMD_TICK);
    status.mode     = mode;
    status.div_done = div_done;
    status.avg_done = avg_step[3];
    status.out_free = out_free;
  end

  // Highest ladder level whose rate lies strictly below the throughput.
  always_comb begin
    sel_bw  = (mode == MODE_SMOOTH) ? avg_bps : last_bps;
    q_found = 1'b0;
    q_level = '0;
    for (int i = 0; i < LADDER_LEVELS; i++) begin
      if (sel_bw > BPS_W'(level_rate(LEVEL_W'(i)))) begin
        q_found = 1'b1;
        q_level = LEVEL_W'(i);
      end
    end
  end

  // Buffer-based level in 5 s steps, capped at the top of the ladder.
  always_comb begin
    b_level = '0;
    for (int k = 1; k < LADDER_LEVELS; k++) begin
      if (32'(buffer_ms) >= BBA_STEP_MS * 32'(k)) begin
        b_level = LEVEL_W'(k);
      end
    end
  end

  assign buf_sum   = {1'b0, buffer_ms} + (BUF_W+1)'(14'(chunk_seconds) * MS_PER_S);
  assign size_prod = 27'(level_rate(next_level)) * 27'(chunk_seconds);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_RESET;
      chunk_seconds <= SECS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:  mode          <= cfg_data[MODE_W-1:0];
        REG_CHUNK: chunk_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
    if (cmd.mul) begin
      product <= DIVIDEND_W'(cur.chunk_bytes) * DIVIDEND_W'(BITS_MS_SCALE);
    end
    if (cmd.capture) begin
      req_valid <= 1'b0;
      req_bytes <= '0;
      delay     <= 1'b0;
    end else if (cmd.select) begin
      delay <= 32'(buffer_ms) >= BUFFER_FULL_MS;
    end else if (cmd.size) begin
      req_valid <= 1'b1;
      req_bytes <= size_prod[26] ? {REQ_W{1'b1}} : size_prod[25:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_ms      <= '0;
      avg_bps        <= '0;
      last_bps       <= '0;
      next_level     <= '0;
      next_level_set <= 1'b0;
      prev_level     <= '0;
      prev_level_set <= 1'b0;
      switches       <= '0;
      draining       <= 1'b0;
    end else begin
      if (cmd.tick && draining) begin
        if (buffer_ms < TICK_MS) begin
          buffer_ms <= '0;
          draining  <= 1'b0;
        end else begin
          buffer_ms <= buffer_ms - TICK_MS;
        end
      end
      if (cmd.take_bps) begin
        if (cur.download_ms == '0 || div_quotient[DIVIDEND_W-1:BPS_W] != '0) begin
          last_bps <= '1;
        end else begin
          last_bps <= div_quotient[BPS_W-1:0];
        end
      end
      if (cmd.buf_add) begin
        buffer_ms <= buf_sum[BUF_W] ? {BUF_W{1'b1}} : buf_sum[BUF_W-1:0];
        draining  <= 1'b1;
      end
      if (cmd.take_avg) begin
        avg_bps <= (avg_bps == '0) ? last_bps : avg_quo;
      end
      if (cmd.select) begin
        if (mode == MODE_BUFFER) begin
          next_level     <= b_level;
          next_level_set <= 1'b1;
        end else if (q_found) begin
          next_level     <= q_level;
          next_level_set <= 1'b1;
        end else if (!next_level_set) begin
          next_level     <= '0;
          next_level_set <= 1'b1;
        end
      end
      if (cmd.size) begin
        if (prev_level_set && prev_level != next_level && switches != {SW_W{1'b1}}) begin
          switches <= switches + 1'b1;
        end
        prev_level     <= next_level;
        prev_level_set <= 1'b1;
      end
    end
  end

  // Result register; the next word may be accepted while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.request_valid   <= req_valid;
      result.level_index     <= prev_level;
      result.request_bytes   <= req_bytes;
      result.delay_request   <= delay;
      result.measured_bps    <= last_bps;
      result.smoothed_bps    <= avg_bps;
      result.buffer_level_ms <= buffer_ms;
      result.switch_total    <= switches;
    end
  end

`ifndef NO_ASSERTIONS
  // A new result must never overwrite one that is still waiting.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result loaded while previous word still stalled");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_avg_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.avg_start |-> (avg_step == '0))
    else $error("average division restarted while running");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    next_level_set |-> (32'(next_level) < LADDER_LEVELS))
    else $error("selected level beyond ladder");

  a_tick_drains: assert property (@(posedge clk) disable iff (rst)
    cmd.tick |=> (buffer_ms <= $past(buffer_ms)))
    else $error("tick raised the buffer level");

  a_switch_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (switches >= $past(switches)))
    else $error("switch count decreased");
`endif

endmodule

/* rtl/core/abr_ctrl.sv */
// ----------------------------------------------------------------------------
// Bitrate selector controller
// Sequences the datapath through tick draining or throughput measurement,
// smoothing, level selection and result delivery for one word at a time.
// ----------------------------------------------------------------------------
module abr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  abr_pkg::status_t   status,
  output abr_pkg::cmd_t      cmd
);
  import abr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status.is_tick) begin
          state_next = ST_TICK;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ST_DIV_T;
        end
      end
      ST_TICK: begin
        cmd.tick   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_DIV_T: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_T;
      end
      ST_WAIT_T: begin
        if (status.div_done) begin
          cmd.take_bps = 1'b1;
          state_next   = ST_BUF;
        end
      end
      ST_BUF: begin
        cmd.buf_add = 1'b1;
        case (status.mode)
          MODE_SMOOTH: state_next = ST_DIV_S;
          MODE_NONE:   state_next = ST_EMIT;
          default:     state_next = ST_SELECT;
        endcase
      end
      ST_DIV_S: begin
        cmd.avg_start = 1'b1;
        state_next    = ST_WAIT_S;
      end
      ST_WAIT_S: begin
        if (status.avg_done) begin
          cmd.take_avg = 1'b1;
          state_next   = ST_SELECT;
        end
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_next = ST_SIZE;
      end
      ST_SIZE: begin
        cmd.size   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/abr_bitrate_selector_core.sv */
// ----------------------------------------------------------------------------
// Adaptive bitrate selector
// Top level: controller, datapath and configuration port.
// ----------------------------------------------------------------------------
// Each input word is a finished chunk or a 100 ms playback tick, and each one
// yields exactly one result word. A tick goes through ST_MUL and ST_TICK
// to ST_EMIT, which loads the result register. A chunk runs through a
// restoring divider that retires one of 37 quotient bits per cycle; modes 0
// and 2 then select a level and size the request, mode 1 first adds a
// reciprocal-multiply division by five for the moving average, and mode 3
// skips selection and sizing. The next word is accepted from the cycle after
// its predecessor reached the result register, even if that result is still
// stalled; a new result then waits until the stalled word has left.
// Configuration writes are always ready and are meant to be made while idle.
module abr_bitrate_selector_core #(
  parameter int unsigned BUFFER_FULL_MS = 30000,
  parameter int unsigned LADDER_LEVELS  = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  abr_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output abr_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [abr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import abr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  abr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  abr_datapath #(
    .BUFFER_FULL_MS (BUFFER_FULL_MS),
    .LADDER_LEVELS  (LADDER_LEVELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

/* sim/abr_bitrate_selector_core_tb.sv */
// ----------------------------------------------------------------------------
// Bitrate selector testbench
// Feeds chunk and tick words through all selection modes and random chunk
// lengths of 1 to 15 s, predicts each result word, and checks it field by
// field as it leaves the block. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abr_bitrate_selector_core_tb;
  import abr_pkg::*;

  localparam int unsigned FULL_MS       = 30000;
  localparam int unsigned LEVELS        = 6;
  localparam int unsigned RANDOM_WORDS  = 900;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned REPORT_MAX    = 10;

  // Tracks the selector state and holds the result words still owed.
  class selector_scoreboard;
    logic [MODE_W-1:0]  mode;
    logic [SECS_W-1:0]  secs;
    logic [BUF_W-1:0]   buffer_ms;
    logic [BPS_W-1:0]   avg_bps;
    logic [BPS_W-1:0]   last_bps;
    logic [LEVEL_W-1:0] next_lvl;
    logic [LEVEL_W-1:0] prev_lvl;
    logic [SW_W-1:0]    switches;
    bit                 next_set;
    bit                 prev_set;
    bit                 draining;
    result_t            expected_words[$];
    int unsigned        mismatches;

    function new();
      mode       = MODE_RESET;
      secs       = SECS_RESET;
      buffer_ms  = '0;
      avg_bps    = '0;
      last_bps   = '0;
      next_lvl   = '0;
      prev_lvl   = '0;
      switches   = '0;
      next_set   = 1'b0;
      prev_set   = 1'b0;
      draining   = 1'b0;
      mismatches = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:  mode = data[MODE_W-1:0];
        REG_CHUNK: secs = data;
        default: ;
      endcase
    endfunction

    // Highest ladder rung strictly below the throughput; no change at or
    // below the lowest rung.
    function void follow_rate(logic [BPS_W-1:0] bw);
      for (int i = 0; i < LEVELS; i++) begin
        if (64'(bw) <= 64'(STEP_BPS) * 64'(i + 1)) break;
        next_lvl = LEVEL_W'(i);
        next_set = 1'b1;
      end
    endfunction

    function void predict_item(item_t w);
      logic [63:0] wide;
      result_t     want;
      want = '0;
      if (w.command == CMD_CHUNK) begin
        if (w.download_ms == '0) begin
          last_bps = '1;
        end else begin
          wide = (64'(w.chunk_bytes) * 64'(BITS_MS_SCALE)) / 64'(w.download_ms);
          last_bps = (wide > 64'hFFFF_FFFF) ? '1 : wide[BPS_W-1:0];
        end
        wide = 64'(buffer_ms) + 64'(secs) * 64'(MS_PER_S);
        buffer_ms = (wide > 64'hFFFF) ? '1 : wide[BUF_W-1:0];
        draining = 1'b1;
        if (mode != MODE_NONE) begin
          if (mode == MODE_RAW) begin
            follow_rate(last_bps);
          end else if (mode == MODE_SMOOTH) begin
            if (avg_bps == '0) begin
              avg_bps = last_bps;
            end else begin
              wide = (64'(avg_bps) * 64'd4 + 64'(last_bps)) / 64'd5;
              avg_bps = wide[BPS_W-1:0];
            end
            follow_rate(avg_bps);
          end else begin
            wide = 64'(buffer_ms / BBA_STEP_MS);
            next_lvl = (wide > LEVELS - 1) ? LEVEL_W'(LEVELS - 1) : wide[LEVEL_W-1:0];
            next_set = 1'b1;
          end
          want.delay_request = (buffer_ms >= FULL_MS);
          if (!next_set) begin
            next_lvl = '0;
            next_set = 1'b1;
          end
          wide = (64'(STEP_BPS) * (64'(next_lvl) + 64'd1) * 64'(secs)) / 64'd8;
          want.request_bytes = (wide > 64'h7F_FFFF) ? '1 : wide[REQ_W-1:0];
          if (prev_set && prev_lvl != next_lvl && switches != '1) switches++;
          prev_lvl = next_lvl;
          prev_set = 1'b1;
          want.request_valid = 1'b1;
        end
      end else if (draining) begin
        if (buffer_ms < TICK_MS) begin
          buffer_ms = '0;
          draining = 1'b0;
        end else begin
          buffer_ms -= TICK_MS;
        end
      end
      want.level_index     = prev_lvl;
      want.measured_bps    = last_bps;
      want.smoothed_bps    = avg_bps;
      want.buffer_level_ms = buffer_ms;
      want.switch_total    = switches;
      expected_words.insert(expected_words.size(), want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result word arrived with none expected: %h", $time, got);
        return;
      end
      want = expected_words.pop_front();
      compare_field("request_valid", 32'(want.request_valid), 32'(got.request_valid));
      compare_field("level_index", 32'(want.level_index), 32'(got.level_index));
      compare_field("request_bytes", 32'(want.request_bytes), 32'(got.request_bytes));
      compare_field("delay_request", 32'(want.delay_request), 32'(got.delay_request));
      compare_field("measured_bps", want.measured_bps, got.measured_bps);
      compare_field("smoothed_bps", want.smoothed_bps, got.smoothed_bps);
      compare_field("buffer_level_ms", 32'(want.buffer_level_ms), 32'(got.buffer_level_ms));
      compare_field("switch_total", 32'(want.switch_total), 32'(got.switch_total));
    endfunction
  endclass

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  item_t                 item         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  bit                    calm         = 1'b0;
  int unsigned           quiet_cycles = 0;
  selector_scoreboard    board        = new();

  abr_bitrate_selector_core #(
    .BUFFER_FULL_MS(FULL_MS),
    .LADDER_LEVELS (LEVELS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= !calm && ($urandom_range(0, 99) < 15);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_word(result);
  end

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t chunk_word(logic [BYTES_W-1:0] bytes, logic [MS_W-1:0] ms);
    item_t w;
    w.command     = CMD_CHUNK;
    w.chunk_bytes = bytes;
    w.download_ms = ms;
    return w;
  endfunction

  // Tick payload bits are don't-care for the block, so they are randomized.
  function automatic item_t tick_word();
    item_t w;
    w.command     = CMD_TICK;
    w.chunk_bytes = BYTES_W'($urandom);
    w.download_ms = MS_W'($urandom);
    return w;
  endfunction

  function automatic item_t random_chunk();
    logic [BYTES_W-1:0] bytes;
    logic [MS_W-1:0]    ms;
    logic [63:0]        wide;
    int unsigned        pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      bytes = BYTES_W'($urandom);
      ms    = MS_W'($urandom_range(1, 65535));
    end else if (pick <= 7) begin
      // Land on or right next to a ladder rung.
      ms    = MS_W'($urandom_range(1, 4000));
      wide  = (64'(STEP_BPS) * 64'($urandom_range(1, 6)) * 64'(ms)) / 64'(BITS_MS_SCALE);
      bytes = wide[BYTES_W-1:0];
      case ($urandom_range(0, 2))
        0: if (bytes != '0) bytes -= 1'b1;
        2: bytes += 1'b1;
        default: ;
      endcase
    end else if (pick == 8) begin
      bytes = ($urandom_range(0, 1) != 0) ? '1 : '0;
      ms    = ($urandom_range(0, 3) == 0) ? '0 : MS_W'($urandom);
    end else begin
      bytes = BYTES_W'($urandom);
      ms    = MS_W'($urandom_range(0, 40));
    end
    return chunk_word(bytes, ms);
  endfunction

  task automatic send_word(input item_t w);
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    board.predict_item(w);
  endtask

  task automatic pace_sender();
    if (!calm && $urandom_range(0, 99) < 15) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic feed(input item_t w);
    send_word(w);
    pace_sender();
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers back to back; valid stays high between the two.
  task automatic configure(input logic [MODE_W-1:0] m, input logic [SECS_W-1:0] s);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= CFG_DATA_W'(m);
    do @(posedge clk); while (!cfg_ready);
    board.apply_register(REG_MODE, CFG_DATA_W'(m));
    cfg_index <= REG_CHUNK;
    cfg_data  <= s;
    do @(posedge clk); while (!cfg_ready);
    board.apply_register(REG_CHUNK, s);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    item_t             w;
    int unsigned       sent;
    int unsigned       count;
    int unsigned       chunk_pm;
    int unsigned       style;
    logic [MODE_W-1:0] m;
    logic [SECS_W-1:0] s;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a tick before any chunk, then one zero-rate chunk that
    // is drained all the way until playback stops.
    feed(tick_word());
    feed(chunk_word('0, '1));
    while (board.draining) feed(tick_word());
    feed(chunk_word(24'd875, 16'd10));
    feed(chunk_word(24'd1, '0));
    feed(chunk_word('1, 16'd1));
    feed(chunk_word(24'd1751, 16'd10));

    wait_for_results();
    configure(MODE_SMOOTH, 4'd15);
    feed(chunk_word('1, '1));
    feed(chunk_word(24'd1, '1));

    wait_for_results();
    configure(MODE_BUFFER, 4'd15);
    feed(random_chunk());
    feed(random_chunk());

    wait_for_results();
    configure(MODE_NONE, 4'd8);
    feed(random_chunk());
    feed(tick_word());

    while (sent < RANDOM_WORDS) begin
      wait_for_results();
      m = ($urandom_range(0, 9) == 0) ? MODE_NONE : MODE_W'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: s = 4'd1;
        1: s = 4'd15;
        default: s = SECS_W'($urandom_range(1, 15));
      endcase
      configure(m, s);
      // Fill-heavy, roughly balanced, or a pure drain run.
      style = $urandom_range(0, 3);
      if (style == 3) begin
        count = board.buffer_ms / 100 + 2;
        if (count > 150) count = 150;
      end else begin
        count = $urandom_range(20, 60);
      end
      chunk_pm = (style == 0) ? 500 : 1500 / (10 * int'(s) + 1);
      for (int i = 0; i < count; i++) begin
        calm = (sent >= 300 && sent < 450);
        if (style != 3 && $urandom_range(0, 999) < chunk_pm) w = random_chunk();
        else w = tick_word();
        send_word(w);
        sent++;
        if ($urandom_range(0, 199) == 0) wait_for_results();
        else pace_sender();
      end
    end

    calm = 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
